@@ rtl/tts_pkg.sv @@
`timescale 1ns / 1ps

package tts_pkg;

	// Header decoder phases
	typedef enum logic [2:0] {
		PH_TYPE   = 3'd0,
		PH_LEN    = 3'd1,
		PH_EXT_HI = 3'd2,
		PH_EXT_LO = 3'd3,
		PH_SKIP   = 3'd4
	} phase_t;

	localparam int CFG_IDX_W = 2;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t CFG_TARGET_TYPE = 2'd0;
	localparam cfg_idx_t CFG_MAX_LENGTH  = 2'd1;
	localparam cfg_idx_t CFG_SEARCH_MODE = 2'd2;

	localparam int FIELD_W = 16;
	localparam int BYTE_W  = 8;

	// Marks a length byte that announces a 16-bit length
	localparam logic [BYTE_W-1:0] EXT_LEN_MARK = 8'hFF;

endpackage

@@ rtl/tlv_type_search.sv @@
`timescale 1ns / 1ps

// Channel | Handshake            | Payload
// --------+----------------------+----------------------------------------------
// in      | in_valid / in_ready  | data_byte, first_byte, start_offset,
//         |                      | message_length
// out     | out_valid / out_ready| found, result_offset, result_length
// cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data (write only, always ready)
//
// One byte is taken every cycle while in_ready is high. A byte beat sits in
// the input register, then the header decoder updates the search state and
// loads the result register, so a beat passes the input register and then the
// result register before its result beat. The decoder state updates once per byte.
// Reset (arst_n low) leaves the search idle until a byte with first_byte set.
// A stalled result register holds the input register, and in_ready drops
// only when both are full.

module tlv_type_search #(
	parameter int POSITION_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,

	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [tts_pkg::BYTE_W-1:0]    data_byte,
	input  logic                          first_byte,
	input  logic [tts_pkg::FIELD_W-1:0]   start_offset,
	input  logic [tts_pkg::FIELD_W-1:0]   message_length,

	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          found,
	output logic [tts_pkg::FIELD_W-1:0]   result_offset,
	output logic [tts_pkg::FIELD_W-1:0]   result_length,

	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [tts_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tts_pkg::FIELD_W-1:0]   cfg_data
);

	import tts_pkg::*;

	localparam int PW = POSITION_BITS;
	// Compare width: holds any position, a 16-bit end and a record size
	// without wrap
	localparam int CW = ((PW > FIELD_W) ? PW : FIELD_W) + 2;

	// Configuration registers
	logic [BYTE_W-1:0]  target_type_q;
	logic [FIELD_W-1:0] max_length_q;
	logic               search_mode_q;

	// Input register
	logic               valid_s1;
	logic [BYTE_W-1:0]  data_s1;
	logic               first_s1;
	logic [FIELD_W-1:0] start_s1;
	logic [FIELD_W-1:0] mlen_s1;

	// Search state
	phase_t             phase_q;
	logic [PW-1:0]      position_q;
	logic [FIELD_W-1:0] end_position_q;
	logic [PW-1:0]      record_start_q;
	logic [BYTE_W-1:0]  record_type_q;
	logic [FIELD_W-1:0] remaining_q;
	logic [BYTE_W-1:0]  high_len_q;
	logic               done_q;

	// Result register
	logic               out_valid_q;
	logic               found_q;
	logic [FIELD_W-1:0] offset_q;
	logic [FIELD_W-1:0] length_q;

	// Decoder outputs
	phase_t             phase_d;
	logic [PW-1:0]      position_d;
	logic [FIELD_W-1:0] end_position_d;
	logic [PW-1:0]      record_start_d;
	logic [BYTE_W-1:0]  record_type_d;
	logic [FIELD_W-1:0] remaining_d;
	logic [BYTE_W-1:0]  high_len_d;
	logic               done_d;
	logic               res_valid_c;
	logic               res_found_c;
	logic [FIELD_W-1:0] res_offset_c;
	logic [FIELD_W-1:0] res_length_c;

	logic               advance;

	// Result register can load when empty or draining this cycle
	assign advance   = !out_valid_q || out_ready;
	assign in_ready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	assign out_valid     = out_valid_q;
	assign found         = found_q;
	assign result_offset = offset_q;
	assign result_length = length_q;

	// Configuration writes; unknown indexes drop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_type_q <= '0;
			max_length_q  <= '1;
			search_mode_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_TARGET_TYPE: target_type_q <= cfg_data[BYTE_W-1:0];
				CFG_MAX_LENGTH:  max_length_q  <= cfg_data;
				CFG_SEARCH_MODE: search_mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Input register: hold while the result register is stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1  <= data_byte;
			first_s1 <= first_byte;
			start_s1 <= start_offset;
			mlen_s1  <= message_length;
		end
	end

	// Header decoder: one byte per cycle while the result register is not stalled
	always_comb begin
		logic [CW-1:0]      pos_w;
		logic [CW-1:0]      pos_inc_w;
		logic [CW-1:0]      end_w;
		logic [CW-1:0]      start_w;
		logic [CW-1:0]      rec_end_w;
		logic [CW-1:0]      next_pos_w;
		logic [CW-1:0]      rec_start_w;
		logic [FIELD_W-1:0] len;
		logic               matched;
		logic               skip;
		logic [FIELD_W-1:0] skip_len;

		phase_d        = phase_q;
		position_d     = position_q;
		end_position_d = end_position_q;
		record_start_d = record_start_q;
		record_type_d  = record_type_q;
		remaining_d    = remaining_q;
		high_len_d     = high_len_q;
		done_d         = done_q;
		res_valid_c    = 1'b0;
		res_found_c    = 1'b0;
		res_offset_c   = '0;
		res_length_c   = '0;
		matched        = 1'b0;
		skip           = 1'b0;
		skip_len       = '0;
		len            = '0;

		// A first byte restarts the search
		start_w = CW'(start_s1);
		if (first_s1) begin
			position_d     = start_w[PW-1:0];
			end_position_d = mlen_s1;
			phase_d        = PH_TYPE;
			remaining_d    = '0;
			high_len_d     = '0;
			done_d         = 1'b0;
		end

		pos_w       = CW'(position_d);
		pos_inc_w   = pos_w + CW'(1);
		end_w       = CW'(end_position_d);
		rec_start_w = CW'(record_start_q);
		rec_end_w   = rec_start_w + CW'(2) + CW'(data_s1);
		next_pos_w  = CW'(position_d + PW'(1));

		if (!done_d) begin
			if (pos_w >= end_w) begin
				// Empty message or position already past the end
				done_d      = 1'b1;
				res_valid_c = 1'b1;
			end else begin
				position_d = position_d + PW'(1);
				case (phase_d)
					PH_TYPE: begin
						record_start_d = position_d - PW'(1);
						record_type_d  = data_s1;
						phase_d        = PH_LEN;
					end
					PH_LEN: begin
						if (!search_mode_q) begin
							if (data_s1 == EXT_LEN_MARK) begin
								phase_d = PH_EXT_HI;
							end else if (record_type_q == target_type_q) begin
								matched      = 1'b1;
								res_offset_c = next_pos_w[FIELD_W-1:0];
								res_length_c = FIELD_W'(data_s1);
							end else begin
								skip     = 1'b1;
								skip_len = FIELD_W'(data_s1);
							end
						end else begin
							if (record_type_q == target_type_q && rec_end_w <= end_w) begin
								matched      = 1'b1;
								len          = FIELD_W'(data_s1) + FIELD_W'(2);
								res_offset_c = rec_start_w[FIELD_W-1:0];
								res_length_c = (len > max_length_q) ? max_length_q : len;
							end else begin
								skip     = 1'b1;
								skip_len = FIELD_W'(data_s1);
							end
						end
					end
					PH_EXT_HI: begin
						high_len_d = data_s1;
						phase_d    = PH_EXT_LO;
					end
					PH_EXT_LO: begin
						len = {high_len_q, data_s1};
						if (record_type_q == target_type_q) begin
							matched      = 1'b1;
							res_offset_c = next_pos_w[FIELD_W-1:0];
							res_length_c = len;
						end else begin
							skip     = 1'b1;
							skip_len = len;
						end
					end
					default: begin
						if (remaining_d != '0) begin
							remaining_d = remaining_d - FIELD_W'(1);
						end
						if (remaining_d == '0) begin
							phase_d = PH_TYPE;
						end
					end
				endcase

				// Enter value skipping for a record of another type or, in whole-record mode, one that does not fit
				if (skip) begin
					remaining_d = skip_len;
					phase_d     = (skip_len == '0) ? PH_TYPE : PH_SKIP;
				end

				if (matched) begin
					done_d      = 1'b1;
					res_valid_c = 1'b1;
					res_found_c = 1'b1;
				end else if (pos_inc_w >= end_w) begin
					// Last byte of the message without a match
					done_d      = 1'b1;
					res_valid_c = 1'b1;
				end
			end
		end
	end

	// Search state advances with each byte that leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_TYPE;
			position_q     <= '0;
			end_position_q <= '0;
			record_start_q <= '0;
			record_type_q  <= '0;
			remaining_q    <= '0;
			high_len_q     <= '0;
			done_q         <= 1'b1;
		end else if (valid_s1 && advance) begin
			phase_q        <= phase_d;
			position_q     <= position_d;
			end_position_q <= end_position_d;
			record_start_q <= record_start_d;
			record_type_q  <= record_type_d;
			remaining_q    <= remaining_d;
			high_len_q     <= high_len_d;
			done_q         <= done_d;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1 && res_valid_c;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && res_valid_c) begin
			found_q  <= res_found_c;
			offset_q <= res_offset_c;
			length_q <= res_length_c;
		end
	end

	// A "not found" beat carries zero offset and length
	a_not_found_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !found_q |-> offset_q == '0 && length_q == '0)
		else $error("not found beat with nonzero payload");

	// Any emitted result ends the search
	a_result_ends_search: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && advance && res_valid_c |=> done_q)
		else $error("search still running after a result");

	// Whole-record mode clips the reported size
	a_clip: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && found_q && search_mode_q |-> length_q <= max_length_q)
		else $error("record length above max_length");

	// An idle search only restarts on a first byte
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && done_q && !first_s1 |-> !res_valid_c)
		else $error("result from an idle search");

endmodule

@@ verif/tb_tlv_type_search.sv @@
`timescale 1ns / 1ps

module tb_tlv_type_search;

	import tts_pkg::*;

	// Worst case is far below this: every byte waiting out a full sender gap
	// and every report a full receiver stall, plus the long hold-off.
	localparam int CYCLE_LIMIT  = 400000;
	// A beat passes the input register and the result register before its report;
	// leave margin before a register write or the verdict.
	localparam int DRAIN_CYCLES = 6;
	localparam int PHASE_BYTES  = 200;

	typedef struct packed {
		logic                found;
		logic [FIELD_W-1:0]  offset;
		logic [FIELD_W-1:0]  length;
	} search_report_t;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	logic [BYTE_W-1:0]   data_byte;
	logic                first_byte;
	logic [FIELD_W-1:0]  start_offset;
	logic [FIELD_W-1:0]  message_length;
	logic                out_valid;
	logic                out_ready;
	logic                found;
	logic [FIELD_W-1:0]  result_offset;
	logic [FIELD_W-1:0]  result_length;
	logic                cfg_valid;
	logic                cfg_ready;
	cfg_idx_t            cfg_index;
	logic [FIELD_W-1:0]  cfg_data;

	// Shadow of the block's registers, updated on each accepted write beat
	logic [BYTE_W-1:0]   want_type;
	logic [FIELD_W-1:0]  size_cap;
	logic                whole_record;

	// Shadow of the header decoder
	phase_t              hdr_phase;
	logic [FIELD_W-1:0]  cur_pos;
	logic [FIELD_W-1:0]  end_pos;
	logic [FIELD_W-1:0]  rec_start;
	logic [BYTE_W-1:0]   rec_type;
	logic [FIELD_W-1:0]  skip_left;
	logic [BYTE_W-1:0]   ext_hi;
	logic                search_idle;

	search_report_t      pending_reports[$];
	search_report_t      oldest_report;

	int                  err_cnt     = 0;
	int                  cycle_cnt   = 0;
	int                  sent_bytes  = 0;
	int                  tx_gap_pct  = 0;
	int                  rx_stall_pct = 0;
	int                  hold_left   = 0;
	int                  stall_left  = 0;
	bit                  calm        = 1'b0;

	tlv_type_search u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.data_byte      (data_byte),
		.first_byte     (first_byte),
		.start_offset   (start_offset),
		.message_length (message_length),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.found          (found),
		.result_offset  (result_offset),
		.result_length  (result_length),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Start skipping the value of a record that is not wanted.
	function automatic void skip_value(input logic [FIELD_W-1:0] len);
		skip_left = len;
		hdr_phase = (len == '0) ? PH_TYPE : PH_SKIP;
	endfunction

	// Advance the decoder shadow by one accepted byte beat. Returns 1 when
	// the beat causes a report, which is then left in rpt.
	function automatic bit search_byte(
		input  logic [BYTE_W-1:0]  b,
		input  logic               fb,
		input  logic [FIELD_W-1:0] so,
		input  logic [FIELD_W-1:0] ml,
		output search_report_t     rpt
	);
		logic [FIELD_W-1:0] p;
		logic [FIELD_W:0]   nxt;
		logic [FIELD_W+1:0] rec_end;
		logic [FIELD_W:0]   rec_size;

		rpt = '0;
		if (fb) begin
			cur_pos     = so;
			end_pos     = ml;
			hdr_phase   = PH_TYPE;
			skip_left   = '0;
			ext_hi      = '0;
			search_idle = 1'b0;
		end
		if (search_idle)
			return 1'b0;

		p = cur_pos;
		// Position already at or past the end: report not found on this byte
		if (p >= end_pos) begin
			search_idle = 1'b1;
			return 1'b1;
		end
		nxt     = {1'b0, p} + 17'd1;
		cur_pos = nxt[FIELD_W-1:0];

		case (hdr_phase)
			PH_TYPE: begin
				rec_start = p;
				rec_type  = b;
				hdr_phase = PH_LEN;
			end
			PH_LEN: begin
				if (!whole_record) begin
					if (b == EXT_LEN_MARK) begin
						hdr_phase = PH_EXT_HI;
					end else if (rec_type == want_type) begin
						search_idle = 1'b1;
						rpt.found   = 1'b1;
						rpt.offset  = nxt[FIELD_W-1:0];
						rpt.length  = {8'h00, b};
						return 1'b1;
					end else begin
						skip_value({8'h00, b});
					end
				end else begin
					// Fit check runs at full width, no wrap
					rec_end = {2'b00, rec_start} + 18'd2 + 18'(b);
					if (rec_type == want_type && rec_end <= {2'b00, end_pos}) begin
						rec_size = 17'd2 + 17'(b);
						if (rec_size > {1'b0, size_cap})
							rec_size = {1'b0, size_cap};
						search_idle = 1'b1;
						rpt.found   = 1'b1;
						rpt.offset  = rec_start;
						rpt.length  = rec_size[FIELD_W-1:0];
						return 1'b1;
					end
					skip_value({8'h00, b});
				end
			end
			PH_EXT_HI: begin
				ext_hi    = b;
				hdr_phase = PH_EXT_LO;
			end
			PH_EXT_LO: begin
				if (rec_type == want_type) begin
					search_idle = 1'b1;
					rpt.found   = 1'b1;
					rpt.offset  = nxt[FIELD_W-1:0];
					rpt.length  = {ext_hi, b};
					return 1'b1;
				end
				skip_value({ext_hi, b});
			end
			default: begin
				if (skip_left != '0)
					skip_left = skip_left - FIELD_W'(1);
				if (skip_left == '0)
					hdr_phase = PH_TYPE;
			end
		endcase

		// Last byte of the message without a match
		if (nxt >= {1'b0, end_pos}) begin
			search_idle = 1'b1;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// Offer one byte beat, hold it until accepted, then predict its report.
	// Offset fields of non-first bytes are don't-care; fill them with noise.
	task automatic send_byte(
		input logic [BYTE_W-1:0]  b,
		input logic               fb,
		input logic [FIELD_W-1:0] so,
		input logic [FIELD_W-1:0] ml
	);
		int             gap;
		search_report_t rpt;

		if (!calm && $urandom_range(0, 99) < tx_gap_pct) begin
			gap = $urandom_range(1, 17);
			@(negedge clk);
			in_valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid       = 1'b1;
		data_byte      = b;
		first_byte     = fb;
		start_offset   = fb ? so : FIELD_W'($urandom);
		message_length = fb ? ml : FIELD_W'($urandom);
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sent_bytes++;
		if (search_byte(data_byte, first_byte, start_offset, message_length, rpt))
			pending_reports.push_back(rpt);
	endtask

	// Drop valid and wait until every report has come and the pipe is empty.
	task automatic wait_for_quiet();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_reports.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [FIELD_W-1:0] val);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			CFG_TARGET_TYPE: want_type    = val[BYTE_W-1:0];
			CFG_MAX_LENGTH:  size_cap     = val;
			CFG_SEARCH_MODE: whole_record = val[0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// One well-formed message: a few records, about a third of them of the
	// wanted type, with random content. Now and then the end is cut short,
	// the message is empty, or it sits right below the top of the space.
	task automatic send_random_message();
		logic [BYTE_W-1:0]  msg[$];
		int                 n_rec;
		int                 vlen;
		int                 so;
		int                 ml;
		int                 top;
		int                 kind;

		n_rec = $urandom_range(1, 4);
		for (int r = 0; r < n_rec; r++) begin
			msg.push_back(($urandom_range(0, 2) == 0) ? want_type : BYTE_W'($urandom));
			if (!whole_record && $urandom_range(0, 5) == 0) begin
				vlen = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535) :
					$urandom_range(0, 6);
				msg.push_back(EXT_LEN_MARK);
				msg.push_back(vlen[15:8]);
				msg.push_back(vlen[7:0]);
			end else begin
				vlen = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) :
					$urandom_range(0, 6);
				msg.push_back(vlen[7:0]);
			end
			// Long values are cut off; the message then ends inside them
			for (int i = 0; i < vlen && i < 8; i++)
				msg.push_back(BYTE_W'($urandom));
		end

		top = 65535 - msg.size();
		so  = ($urandom_range(0, 9) == 0) ? top - $urandom_range(0, 3) :
			$urandom_range(0, top);
		kind = $urandom_range(0, 9);
		if (kind == 0)
			ml = so + $urandom_range(0, msg.size());
		else if (kind == 1)
			ml = $urandom_range(0, 65535);
		else
			ml = so + msg.size();

		for (int i = 0; i < msg.size(); i++)
			send_byte(msg[i], i == 0, FIELD_W'(so), FIELD_W'(ml));
		// Bytes past the end must be ignored
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 3))
				send_byte(BYTE_W'($urandom), 1'b0, '0, '0);
	endtask

	task automatic send_noise(input int n);
		repeat (n)
			send_byte(BYTE_W'($urandom), $urandom_range(0, 3) == 0,
				FIELD_W'($urandom), FIELD_W'($urandom));
	endtask

	// Value mode: plain and extended lengths, a skipped record, empty
	// message, header cut by the end, a record running past the end near
	// the top of the offset space, and bytes while the search is idle.
	task automatic test_value_mode();
		write_reg(CFG_TARGET_TYPE, 16'h0011);
		// Idle after reset: ignored
		send_byte(8'h00, 1'b0, '0, '0);
		// Match on the first record; trailing bytes ignored
		send_byte(8'h11, 1'b1, 16'h0010, 16'h0014);
		send_byte(8'h02, 1'b0, '0, '0);
		send_byte(8'hAA, 1'b0, '0, '0);
		send_byte(8'hBB, 1'b0, '0, '0);
		// Skip one record, then an extended-length match
		send_byte(8'h33, 1'b1, 16'h0100, 16'h0200);
		send_byte(8'h01, 1'b0, '0, '0);
		send_byte(8'h55, 1'b0, '0, '0);
		send_byte(8'h11, 1'b0, '0, '0);
		send_byte(EXT_LEN_MARK, 1'b0, '0, '0);
		send_byte(8'h12, 1'b0, '0, '0);
		send_byte(8'h34, 1'b0, '0, '0);
		// Empty message
		send_byte(8'hFF, 1'b1, 16'hFFFF, 16'h0000);
		// Header cut off after the type byte
		send_byte(8'h11, 1'b1, 16'h0000, 16'h0001);
		// Skipped record runs past the end at the top of the space
		send_byte(8'h22, 1'b1, 16'hFFFB, 16'hFFFF);
		send_byte(8'h09, 1'b0, '0, '0);
		send_byte(8'h01, 1'b0, '0, '0);
		send_byte(8'h02, 1'b0, '0, '0);
	endtask

	// Change the mode in the middle of a record: the extended header that
	// started in value mode completes, then whole-record rules apply.
	task automatic test_mode_switch();
		send_byte(8'h44, 1'b1, 16'h0020, 16'h0040);
		send_byte(EXT_LEN_MARK, 1'b0, '0, '0);
		wait_for_quiet();
		write_reg(CFG_TARGET_TYPE, 16'h00FF);
		write_reg(CFG_MAX_LENGTH, 16'd4);
		write_reg(CFG_SEARCH_MODE, 16'd1);
		send_byte(8'h00, 1'b0, '0, '0);
		send_byte(8'h01, 1'b0, '0, '0);
		send_byte(8'h99, 1'b0, '0, '0);
		// Fits, size 9 clipped to 4
		send_byte(8'hFF, 1'b0, '0, '0);
		send_byte(8'h07, 1'b0, '0, '0);
		wait_for_quiet();
	endtask

	// Hold the receiver off while empty messages keep coming, so the block
	// fills and stalls its input; then pause until every report is in.
	task automatic test_backpressure();
		int so;

		tx_gap_pct   = 0;
		rx_stall_pct = 0;
		hold_left    = 150;
		repeat (60) begin
			so = $urandom_range(1, 65535);
			send_byte(BYTE_W'($urandom), 1'b1, FIELD_W'(so),
				FIELD_W'($urandom_range(0, so)));
		end
		wait_for_quiet();
	endtask

	// Random messages over several register settings; the last phase runs
	// with no idling on either side.
	task automatic test_random_traffic();
		int          start_cnt;
		logic [15:0] cap;

		for (int ph = 0; ph < 8; ph++) begin
			wait_for_quiet();
			case (ph % 4)
				0:       cap = 16'hFFFF;
				1:       cap = 16'h0000;
				2:       cap = FIELD_W'($urandom_range(0, 12));
				default: cap = FIELD_W'($urandom);
			endcase
			write_reg(CFG_TARGET_TYPE, (ph == 0) ? 16'h0000 :
				(ph == 1) ? 16'h00FF : FIELD_W'($urandom_range(0, 255)));
			write_reg(CFG_MAX_LENGTH, cap);
			write_reg(CFG_SEARCH_MODE, FIELD_W'(ph % 2));
			tx_gap_pct   = (ph % 3 == 0) ? 0 : 30;
			rx_stall_pct = (ph % 3 == 1) ? 0 : 30;
			calm         = (ph == 7);
			start_cnt    = sent_bytes;
			while (sent_bytes - start_cnt < PHASE_BYTES) begin
				if ($urandom_range(0, 9) == 0)
					send_noise($urandom_range(1, 6));
				else
					send_random_message();
			end
		end
		wait_for_quiet();
	endtask

	// Receiver: random stall bursts, long hold-off on request
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				out_ready = 1'b0;
				hold_left--;
			end else if (calm) begin
				out_ready = 1'b1;
			end else if (stall_left > 0) begin
				out_ready = 1'b0;
				stall_left--;
			end else if ($urandom_range(0, 99) < rx_stall_pct) begin
				out_ready  = 1'b0;
				stall_left = $urandom_range(1, 17) - 1;
			end else begin
				out_ready = 1'b1;
			end
		end
	end

	// Compare each report beat with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_reports.size() == 0) begin
				err_cnt++;
				$display("%0t: report expected none actual found=%0b offset=%h length=%h",
					$time, found, result_offset, result_length);
			end else begin
				oldest_report = pending_reports.pop_front();
				if (found !== oldest_report.found) begin
					err_cnt++;
					$display("%0t: found expected %0b actual %0b",
						$time, oldest_report.found, found);
				end
				if (result_offset !== oldest_report.offset) begin
					err_cnt++;
					$display("%0t: result_offset expected %h actual %h",
						$time, oldest_report.offset, result_offset);
				end
				if (result_length !== oldest_report.length) begin
					err_cnt++;
					$display("%0t: result_length expected %h actual %h",
						$time, oldest_report.length, result_length);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		data_byte      = '0;
		first_byte     = 1'b0;
		start_offset   = '0;
		message_length = '0;
		cfg_valid      = 1'b0;
		cfg_index      = CFG_TARGET_TYPE;
		cfg_data       = '0;

		// Reset values of the registers and the decoder
		want_type    = '0;
		size_cap     = 16'hFFFF;
		whole_record = 1'b0;
		hdr_phase    = PH_TYPE;
		cur_pos      = '0;
		end_pos      = '0;
		rec_start    = '0;
		rec_type     = '0;
		skip_left    = '0;
		ext_hi       = '0;
		search_idle  = 1'b1;

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_value_mode();
		test_mode_switch();
		test_backpressure();
		test_random_traffic();

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_cnt == 0 && pending_reports.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
